// File: rtl/core/tlmc_pkg.sv
// constants and codes shared by the two-axis linear move controller
// no dependencies: compiled first
`default_nettype none

package tlmc_pkg;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_SPEED = 1'b0;
    localparam logic REG_TOL   = 1'b1;

    // register widths and reset values
    localparam int SPEED_W = 7;
    localparam int TOL_W   = 16;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;
    localparam logic [SPEED_W-1:0] SPEED_RST = 7'd25;
    localparam logic [TOL_W-1:0]   TOL_RST   = 16'd15;

    // result and arithmetic widths
    localparam int PWR_W  = 8;
    localparam int S2_W   = 2 * SPEED_W;   // speed squared, also quotient width
    localparam int ROOT_W = SPEED_W;
    localparam int CNT_W  = $clog2(S2_W);

    // command codes
    localparam logic OP_START = 1'b0;

endpackage

`default_nettype wire

// File: rtl/core/tlmc_cmd_if.sv
// command channel of the move controller: start and tick words
// depends on nothing but its position parameter
`default_nettype none

interface tlmc_cmd_if #(
    parameter int POS_BITS = 32
);
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic signed [POS_BITS-1:0] target_x;
    logic signed [POS_BITS-1:0] target_y;
    logic signed [POS_BITS-1:0] enc_x;
    logic signed [POS_BITS-1:0] enc_y;

    modport source (output valid, op, target_x, target_y, enc_x, enc_y, input ready);
    modport sink   (input valid, op, target_x, target_y, enc_x, enc_y, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tlmc_rsp_if.sv
// result channel of the move controller: drive and status words
// uses tlmc_pkg for the drive width
`default_nettype none

interface tlmc_rsp_if;
    import tlmc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [PWR_W-1:0] power_x;
    logic signed [PWR_W-1:0] power_y;
    logic                    busy_res;
    logic                    done_res;

    modport source (output valid, power_x, power_y, busy_res, done_res, input ready);
    modport sink   (input valid, power_x, power_y, busy_res, done_res, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tlmc_alu.sv
// shared wide adder / subtractor of the drive calculation
// carry out doubles as the a >= b flag when subtracting
`default_nettype none

module tlmc_alu #(
    parameter int WIDTH = 78
) (
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    input  wire logic             sub,
    output logic      [WIDTH-1:0] sum,
    output logic                  carry
);
    logic [WIDTH-1:0] b_inv;

    assign b_inv = sub ? ~b : b;
    assign {carry, sum} = {1'b0, a} + {1'b0, b_inv} + {{WIDTH{1'b0}}, sub};
endmodule

`default_nettype wire

// File: rtl/core/tlmc_drive.sv
// drive calculation: |q| = isqrt(floor(s^2 * d^2 / (dx^2 + dy^2))) per axis
// sequencer around tlmc_alu (shift-add multiply, restoring divide); uses tlmc_pkg
`default_nettype none

module tlmc_drive #(
    parameter int POS_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic signed [POS_BITS:0]       dx,
    input  wire logic signed [POS_BITS:0]       dy,
    input  wire logic [tlmc_pkg::SPEED_W-1:0]   spd,
    output logic                                done,
    output logic signed [tlmc_pkg::PWR_W-1:0]   drive_x,
    output logic signed [tlmc_pkg::PWR_W-1:0]   drive_y
);
    import tlmc_pkg::*;

    localparam int MAG_W  = POS_BITS;
    localparam int SQ_W   = 2 * POS_BITS;
    localparam int D_W    = 2 * POS_BITS + 1;
    localparam int W      = 2 * POS_BITS + S2_W;
    localparam int DIV_SH = S2_W - 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQA  = 3'd1;
    localparam logic [2:0] S_SQB  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_NMUL = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_ROOT = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]              state_reg, state_next;
    logic signed [PWR_W-1:0] drv_x_reg, drv_x_next;
    logic signed [PWR_W-1:0] drv_y_reg, drv_y_next;

    logic [MAG_W-1:0]  mag_x_reg, mag_x_next, mag_y_reg, mag_y_next;
    logic              neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [S2_W-1:0]   s2_reg, s2_next;
    logic [SQ_W-1:0]   sq_x_reg, sq_x_next, sq_y_reg, sq_y_next;
    logic [D_W-1:0]    d_reg, d_next;
    logic [W-1:0]      acc_reg, acc_next, mcand_reg, mcand_next;
    logic [MAG_W-1:0]  mplier_reg, mplier_next;
    logic [S2_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic              ax_reg, ax_next;

    logic [MAG_W-1:0]  mag_x_in, mag_y_in;
    logic [S2_W-1:0]   spd_ext, spd_sq;
    logic [W-1:0]      alu_a, alu_b, alu_sum;
    logic              alu_sub, alu_carry;
    logic [ROOT_W-1:0] trial, root_new;
    logic [S2_W-1:0]   trial_ext, trial_sq;
    logic signed [PWR_W-1:0] root_s, sdrv;

    assign mag_x_in  = MAG_W'(dx[POS_BITS] ? -dx : dx);
    assign mag_y_in  = MAG_W'(dy[POS_BITS] ? -dy : dy);
    assign spd_ext   = S2_W'(spd);
    assign spd_sq    = spd_ext * spd_ext;

    // one root bit a step
    assign trial     = root_reg | (ROOT_W'(1) << cnt_reg[$clog2(ROOT_W)-1:0]);
    assign trial_ext = S2_W'(trial);
    assign trial_sq  = trial_ext * trial_ext;
    assign root_new  = (trial_sq <= quo_reg) ? trial : root_reg;
    assign root_s    = PWR_W'(root_new);
    assign sdrv      = (ax_reg ? neg_y_reg : neg_x_reg) ? -root_s : root_s;

    always_comb
    begin
        if (state_reg == S_SUM)
        begin
            alu_a = W'(sq_x_reg);
            alu_b = W'(sq_y_reg);
        end
        else
        begin
            alu_a = acc_reg;
            alu_b = mcand_reg;
        end
        alu_sub = (state_reg == S_DIV);
    end

    tlmc_alu #(
        .WIDTH (W)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    always_comb
    begin
        state_next  = state_reg;
        drv_x_next  = drv_x_reg;
        drv_y_next  = drv_y_reg;
        mag_x_next  = mag_x_reg;
        mag_y_next  = mag_y_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        s2_next     = s2_reg;
        sq_x_next   = sq_x_reg;
        sq_y_next   = sq_y_reg;
        d_next      = d_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        root_next   = root_reg;
        ax_next     = ax_reg;
        done        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mag_x_next  = mag_x_in;
                    mag_y_next  = mag_y_in;
                    neg_x_next  = dx[POS_BITS];
                    neg_y_next  = dy[POS_BITS];
                    s2_next     = spd_sq;
                    acc_next    = '0;
                    mcand_next  = W'(mag_x_in);
                    mplier_next = mag_x_in;
                    if (mag_x_in == '0 && mag_y_in == '0)
                    begin
                        // zero-length move
                        drv_x_next = '0;
                        drv_y_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SQA;
                    end
                end
            end
            S_SQA, S_SQB, S_NMUL:
            begin
                if (mplier_reg == '0)
                begin
                    if (state_reg == S_SQA)
                    begin
                        sq_x_next   = acc_reg[SQ_W-1:0];
                        acc_next    = '0;
                        mcand_next  = W'(mag_y_reg);
                        mplier_next = mag_y_reg;
                        state_next  = S_SQB;
                    end
                    else if (state_reg == S_SQB)
                    begin
                        sq_y_next  = acc_reg[SQ_W-1:0];
                        state_next = S_SUM;
                    end
                    else
                    begin
                        // acc holds the numerator, set up the divisor
                        mcand_next = W'(d_reg) << DIV_SH;
                        quo_next   = '0;
                        cnt_next   = CNT_W'(DIV_SH);
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = alu_sum;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end
            S_SUM:
            begin
                d_next      = alu_sum[D_W-1:0];
                ax_next     = 1'b0;
                acc_next    = '0;
                mcand_next  = W'(sq_x_reg);
                mplier_next = MAG_W'(s2_reg);
                state_next  = S_NMUL;
            end
            S_DIV:
            begin
                if (alu_carry)
                begin
                    acc_next = alu_sum;
                end
                quo_next   = {quo_reg[S2_W-2:0], alu_carry};
                mcand_next = mcand_reg >> 1;
                if (cnt_reg == '0)
                begin
                    root_next  = '0;
                    cnt_next   = CNT_W'(ROOT_W - 1);
                    state_next = S_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_ROOT:
            begin
                root_next = root_new;
                if (cnt_reg == '0)
                begin
                    if (!ax_reg)
                    begin
                        drv_x_next  = sdrv;
                        ax_next     = 1'b1;
                        acc_next    = '0;
                        mcand_next  = W'(sq_y_reg);
                        mplier_next = MAG_W'(s2_reg);
                        state_next  = S_NMUL;
                    end
                    else
                    begin
                        drv_y_next = sdrv;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            drv_x_reg <= '0;
            drv_y_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drv_x_reg <= drv_x_next;
            drv_y_reg <= drv_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_x_reg  <= mag_x_next;
        mag_y_reg  <= mag_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        s2_reg     <= s2_next;
        sq_x_reg   <= sq_x_next;
        sq_y_reg   <= sq_y_next;
        d_reg      <= d_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        root_reg   <= root_next;
        ax_reg     <= ax_next;
    end

    assign drive_x = drv_x_reg;
    assign drive_y = drv_y_reg;
endmodule

`default_nettype wire

// File: rtl/core/two_axis_linear_move_controller.sv
// two-axis linear move controller, top level; uses tlmc_pkg, tlmc_cmd_if, tlmc_rsp_if, tlmc_drive
// start word: result valid once the drive calculation is done and the result register is free;
//   its shift-add squares and divides use the one shared adder, its root steps their own squarer
// tick word: result registered via T_FIN once the output is free; next word taken in T_IDLE
// one word in flight; the result register lets the next word in while a result waits
// async active-low reset: idle, no move, drives zero, speed 25, tolerance 15
`default_nettype none

module two_axis_linear_move_controller #(
    parameter int POS_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tlmc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tlmc_pkg::DATA_W-1:0]   pwdata,
    output logic      [tlmc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    tlmc_cmd_if.sink                           cmd,
    tlmc_rsp_if.source                         rsp
);
    import tlmc_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_CALC = 2'd1;
    localparam logic [1:0] T_FIN  = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [SPEED_W-1:0]         speed_reg;
    logic [TOL_W-1:0]           tol_reg;
    logic signed [POS_BITS-1:0] goal_x_reg, goal_x_next, goal_y_reg, goal_y_next;
    logic [1:0]                 running_reg, running_next;
    logic                       moving_reg, moving_next;
    logic                       out_valid_reg, out_valid_next;

    logic                       op_reg, op_next;
    logic signed [POS_BITS-1:0] enc_x_reg, enc_x_next, enc_y_reg, enc_y_next;
    logic signed [PWR_W-1:0]    pwr_x_reg, pwr_x_next, pwr_y_reg, pwr_y_next;
    logic                       busy_reg, busy_next, done_reg, done_next;

    logic                       cfg_wr;
    logic                       accept, calc_start, calc_done, out_free;
    logic [SPEED_W-1:0]         spd_clamp;
    logic signed [POS_BITS:0]   dx_in, dy_in, err_x, err_y;
    logic [POS_BITS-1:0]        err_mag_x, err_mag_y;
    logic signed [PWR_W-1:0]    drive_x, drive_y;
    logic                       in_x, in_y, mov_base, mov_new, done_new;
    logic [1:0]                 run_base, run_new;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= SPEED_RST;
            tol_reg   <= TOL_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[ADDR_W-1] == REG_SPEED)
            begin
                speed_reg <= pwdata[SPEED_W-1:0];
            end
            else
            begin
                tol_reg <= pwdata[TOL_W-1:0];
            end
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_TOL) ? DATA_W'(tol_reg) : DATA_W'(speed_reg);

    // command side
    assign cmd.ready  = (state_reg == T_IDLE);
    assign accept     = cmd.valid & cmd.ready;
    assign calc_start = accept & (cmd.op == OP_START);
    assign spd_clamp  = (speed_reg > SPEED_MAX) ? SPEED_MAX : speed_reg;
    assign dx_in      = {cmd.target_x[POS_BITS-1], cmd.target_x}
                      - {cmd.enc_x[POS_BITS-1], cmd.enc_x};
    assign dy_in      = {cmd.target_y[POS_BITS-1], cmd.target_y}
                      - {cmd.enc_y[POS_BITS-1], cmd.enc_y};

    tlmc_drive #(
        .POS_BITS (POS_BITS)
    ) u_drive (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (calc_start),
        .dx      (dx_in),
        .dy      (dy_in),
        .spd     (spd_clamp),
        .done    (calc_done),
        .drive_x (drive_x),
        .drive_y (drive_y)
    );

    // tolerance check on the latched encoder counts
    assign err_x     = {goal_x_reg[POS_BITS-1], goal_x_reg} - {enc_x_reg[POS_BITS-1], enc_x_reg};
    assign err_y     = {goal_y_reg[POS_BITS-1], goal_y_reg} - {enc_y_reg[POS_BITS-1], enc_y_reg};
    assign err_mag_x = POS_BITS'(err_x[POS_BITS] ? -err_x : err_x);
    assign err_mag_y = POS_BITS'(err_y[POS_BITS] ? -err_y : err_y);
    assign in_x      = (err_mag_x <= POS_BITS'(tol_reg));
    assign in_y      = (err_mag_y <= POS_BITS'(tol_reg));

    always_comb
    begin
        run_base = (op_reg == OP_START) ? 2'b11 : running_reg;
        mov_base = (op_reg == OP_START) | moving_reg;
        run_new  = run_base;
        mov_new  = mov_base;
        done_new = 1'b0;
        if (mov_base)
        begin
            // a stopped axis stays stopped
            run_new = run_base & ~{in_y, in_x};
            if (in_x && in_y)
            begin
                run_new  = 2'b00;
                mov_new  = 1'b0;
                done_new = 1'b1;
            end
        end
    end

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        goal_x_next    = goal_x_reg;
        goal_y_next    = goal_y_reg;
        running_next   = running_reg;
        moving_next    = moving_reg;
        out_valid_next = out_valid_reg & ~rsp.ready;
        op_next        = op_reg;
        enc_x_next     = enc_x_reg;
        enc_y_next     = enc_y_reg;
        pwr_x_next     = pwr_x_reg;
        pwr_y_next     = pwr_y_reg;
        busy_next      = busy_reg;
        done_next      = done_reg;

        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    op_next    = cmd.op;
                    enc_x_next = cmd.enc_x;
                    enc_y_next = cmd.enc_y;
                    if (cmd.op == OP_START)
                    begin
                        goal_x_next = cmd.target_x;
                        goal_y_next = cmd.target_y;
                        state_next  = T_CALC;
                    end
                    else
                    begin
                        state_next = T_FIN;
                    end
                end
            end
            T_CALC:
            begin
                if (calc_done)
                begin
                    state_next = T_FIN;
                end
            end
            T_FIN:
            begin
                if (out_free)
                begin
                    running_next   = run_new;
                    moving_next    = mov_new;
                    pwr_x_next     = run_new[0] ? drive_x : '0;
                    pwr_y_next     = run_new[1] ? drive_y : '0;
                    busy_next      = mov_new;
                    done_next      = done_new;
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            running_reg   <= 2'b00;
            moving_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
            running_reg   <= running_next;
            moving_reg    <= moving_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        enc_x_reg <= enc_x_next;
        enc_y_reg <= enc_y_next;
        pwr_x_reg <= pwr_x_next;
        pwr_y_reg <= pwr_y_next;
        busy_reg  <= busy_next;
        done_reg  <= done_next;
    end

    // result word
    assign rsp.valid    = out_valid_reg;
    assign rsp.power_x  = pwr_x_reg;
    assign rsp.power_y  = pwr_y_reg;
    assign rsp.busy_res = busy_reg;
    assign rsp.done_res = done_reg;
endmodule

`default_nettype wire
